>>> hdl/lpht_pkg.sv
`default_nettype none
// ============================================================================
// lpht_pkg
// Shared constants, request/response beat types and the control/status
// structs that join the linear-probing hash table controller and datapath.
// ============================================================================
package lpht_pkg;

    // table geometry
    localparam int TABLE_SIZE    = 23;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int KEY_W         = 31;
    localparam int SLOT_W        = $clog2(TABLE_SIZE);
    localparam int COUNT_W       = $clog2(TABLE_SIZE + 1);

    // key mod TABLE_SIZE by reciprocal multiplication:
    // q = (key * HASH_MUL) >> HASH_SH is exact for every KEY_W-bit key,
    // then rem = key - q * TABLE_SIZE, each step registered
    localparam int HASH_SH    = KEY_W + $clog2(TABLE_SIZE);
    localparam int MUL_W      = KEY_W + 1;
    localparam int PROD_W     = KEY_W + MUL_W;
    localparam int HASH_STEPS = 3;
    localparam int DCNT_W     = $clog2(HASH_STEPS);
    localparam logic [MUL_W-1:0] HASH_MUL =
        MUL_W'(((64'd1 << HASH_SH) / 64'(TABLE_SIZE)) + 64'd1);

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // response status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic [KEY_W-1:0]         key;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] count;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic hash_step;
        logic probe_step;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic hash_last;
        logic hit;
        logic miss;
    } t_sts;

endpackage
`default_nettype wire

>>> hdl/linear_probe_hash_table.sv
`default_nettype none
// ============================================================================
// linear_probe_hash_table
// Open-addressing hash table with linear probing: insert or remove one
// entry per request, one result beat per request.
// ============================================================================
//
//  channel   signals                  beat taken when
//  --------  -----------------------  -------------------------
//  request   start, busy, i_req       start && !busy at clk edge
//  result    o_done, o_rsp            o_done high (one cycle)
//
//  Home slot is key mod 23 by reciprocal multiplication.
//  Then one probe per cycle, with the key read from a registered store
//  port on remove; the result beat follows in the cycle after the deciding
//  probe. A walk probes at most 23 slots, and fails when it finds no slot.
//  Synchronous active-low reset empties the table; the result side never
//  stalls, and a new request may be taken in the result beat's cycle.
//
module linear_probe_hash_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  lpht_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output lpht_pkg::t_rsp o_rsp
);
    import lpht_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    lpht_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    lpht_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

endmodule
`default_nettype wire

>>> hdl/lpht_datapath.sv
`default_nettype none
// ============================================================================
// lpht_datapath
// Request registers, pipelined key-mod-table-size reduction, probe pointer,
// occupancy bits, key/payload store, entry count and the result register.
// ============================================================================
module lpht_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpht_pkg::t_req i_req,
    input  lpht_pkg::t_cmd i_cmd,
    output lpht_pkg::t_sts o_sts,
    output lpht_pkg::t_rsp o_rsp,
    output logic           o_done
);
    import lpht_pkg::*;

    // request held for the whole operation
    logic                     r_mode;
    logic [KEY_W-1:0]         r_key;
    logic [PAYLOAD_WIDTH-1:0] r_pay;

    // hash reduction
    logic [DCNT_W-1:0] r_dig;
    logic [PROD_W-1:0] r_prod;
    logic [KEY_W-1:0]  r_qd;
    logic [KEY_W-1:0]  w_rem_full;
    logic [SLOT_W-1:0] n_rem;

    // probe walk
    logic [SLOT_W-1:0]  r_idx;
    logic [SLOT_W-1:0]  w_next_idx;
    logic [COUNT_W-1:0] r_issued;
    logic               w_probe_live;
    logic               r_rd_vld;
    logic [SLOT_W-1:0]  r_rd_idx;
    logic [KEY_W-1:0]   r_rd_key;
    logic               w_key_match;
    logic               w_hit;
    logic               w_miss;
    logic [SLOT_W-1:0]  w_hit_slot;

    // table state
    logic [TABLE_SIZE-1:0]    r_occ;
    logic [COUNT_W-1:0]       r_count;
    logic [COUNT_W-1:0]       n_count;
    logic [KEY_W-1:0]         mem_key [TABLE_SIZE];
    logic [PAYLOAD_WIDTH-1:0] mem_pay [TABLE_SIZE];

    // result
    t_rsp r_rsp;
    logic r_done;

    // remainder from the registered quotient product; always below TABLE_SIZE
    always_comb begin
        w_rem_full = r_key - r_qd;
        n_rem      = w_rem_full[SLOT_W-1:0];
    end

    // probe decisions; remove compares the registered key read at r_rd_idx
    assign w_probe_live = (r_issued != COUNT_W'(TABLE_SIZE));
    assign w_next_idx   = (r_idx == SLOT_W'(TABLE_SIZE - 1)) ? '0 : SLOT_W'(r_idx + 1'b1);
    assign w_key_match  = r_rd_vld && r_occ[r_rd_idx] && (r_rd_key == r_key);

    always_comb begin
        if (r_mode == MODE_INSERT) begin
            w_hit      = w_probe_live && !r_occ[r_idx];
            w_miss     = !w_probe_live;
            w_hit_slot = r_idx;
        end else begin
            w_hit      = w_key_match;
            w_miss     = !w_key_match && !w_probe_live && !r_rd_vld;
            w_hit_slot = r_rd_idx;
        end
    end

    // entry count after a successful request
    always_comb begin
        n_count = r_count;
        if (w_hit) begin
            if (r_mode == MODE_INSERT) begin
                n_count = COUNT_W'(r_count + 1'b1);
            end else if (r_count != '0) begin
                n_count = COUNT_W'(r_count - 1'b1);
            end
        end
    end

    assign o_sts.hash_last = (r_dig == DCNT_W'(HASH_STEPS - 1));
    assign o_sts.hit       = w_hit;
    assign o_sts.miss      = w_miss;

    // control state: occupancy, count, read-valid, done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= i_cmd.finish;
            r_rd_vld <= i_cmd.probe_step && w_probe_live;
            if (i_cmd.finish && w_hit) begin
                r_occ[w_hit_slot] <= (r_mode == MODE_INSERT);
                r_count           <= n_count;
            end
        end
    end

    // request, hash, probe and result registers (no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_req.mode;
            r_key  <= i_req.key;
            r_pay  <= i_req.payload;
            r_dig  <= '0;
        end
        // three-stage pipe: product, quotient times size, remainder
        if (i_cmd.hash_step) begin
            r_prod <= PROD_W'(r_key) * PROD_W'(HASH_MUL);
            r_qd   <= KEY_W'(KEY_W'(r_prod[PROD_W-1:HASH_SH]) * KEY_W'(TABLE_SIZE));
            r_dig  <= DCNT_W'(r_dig + 1'b1);
            if (o_sts.hash_last) begin
                r_idx    <= n_rem;
                r_issued <= '0;
            end
        end
        if (i_cmd.probe_step) begin
            r_idx    <= w_next_idx;
            r_rd_idx <= r_idx;
            if (w_probe_live) begin
                r_issued <= COUNT_W'(r_issued + 1'b1);
            end
        end
        if (i_cmd.finish) begin
            r_rsp.status <= w_hit ? STATUS_OK : STATUS_FAIL;
            r_rsp.slot   <= w_hit ? w_hit_slot : '0;
            r_rsp.count  <= n_count;
        end
    end

    // key/payload store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && w_hit && (r_mode == MODE_INSERT)) begin
            mem_key[r_idx] <= r_key;
            mem_pay[r_idx] <= r_pay;
        end
        r_rd_key <= mem_key[r_idx];
    end

    assign o_rsp  = r_rsp;
    assign o_done = r_done;

endmodule
`default_nettype wire

>>> hdl/lpht_controller.sv
`default_nettype none
// ============================================================================
// lpht_controller
// Sequencer for one request: hash reduction, probe walk, then finish.
// ============================================================================
module lpht_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lpht_pkg::t_sts i_sts,
    output lpht_pkg::t_cmd o_cmd,
    output logic           o_busy
);
    import lpht_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HASH  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_busy = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.hit || i_sts.miss) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.probe_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> hdl/lpht_checker.sv
`default_nettype none
// ============================================================================
// lpht_checker
// Port-level checks on the hash table's request and result beats.
// ============================================================================
module lpht_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input lpht_pkg::t_rsp o_rsp
);
    import lpht_pkg::*;

    // a taken request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // the result beat only appears once the block has finished
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // failed request reports slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == STATUS_FAIL)) |-> (o_rsp.slot == '0))
        else $error("failed request with non-zero slot");

    // slot and count stay within the table
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((o_rsp.slot < SLOT_W'(TABLE_SIZE)) &&
                    (o_rsp.count <= COUNT_W'(TABLE_SIZE))))
        else $error("slot or count out of range");

endmodule

bind linear_probe_hash_table lpht_checker u_checker (.*);
`default_nettype wire

>>> dv/tb_linear_probe_hash_table.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_linear_probe_hash_table
// Self-checking bench for the linear-probing hash table. A driver presents
// insert and remove requests from a queue. An in-bench shadow of the table
// works out the status, slot and count for each accepted beat. A monitor
// compares every result beat with the oldest outstanding prediction.
// ============================================================================
module tb_linear_probe_hash_table;

    import lpht_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 64;
    localparam int POOL_N         = 16;
    localparam int RANDOM_PER_SET = 470;

    // DUT connections
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // shadow table
    bit                       shadow_used [TABLE_SIZE];
    logic [KEY_W-1:0]         shadow_key  [TABLE_SIZE];
    logic [PAYLOAD_WIDTH-1:0] shadow_pay  [TABLE_SIZE];
    int unsigned              shadow_count;

    // request and prediction queues
    t_req req_q[$];
    t_rsp rsp_due_q[$];

    logic [KEY_W-1:0] key_pool [POOL_N];
    int               send_idle_pct = 0;
    logic             req_taken     = 1'b0;
    int               mismatches    = 0;
    int               quiet_cycles  = 0;

    linear_probe_hash_table uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Apply one request to the shadow table and return the result it gives
    function automatic t_rsp table_apply(input t_req req);
        t_rsp        r;
        int unsigned k;
        int unsigned home;
        int unsigned idx;
        bit          hit;
        r.status = STATUS_FAIL;
        r.slot   = '0;
        k        = req.key;
        home     = k % TABLE_SIZE;
        hit      = 1'b0;
        for (int i = 0; i < TABLE_SIZE && !hit; i++) begin
            idx = (home + i) % TABLE_SIZE;
            if (req.mode == MODE_INSERT) begin
                if (!shadow_used[idx]) begin
                    shadow_used[idx] = 1'b1;
                    shadow_key[idx]  = req.key;
                    shadow_pay[idx]  = req.payload;
                    shadow_count++;
                    hit = 1'b1;
                end
            end else if (shadow_used[idx] && shadow_key[idx] == req.key) begin
                shadow_used[idx] = 1'b0;
                shadow_key[idx]  = '0;
                shadow_pay[idx]  = '0;
                if (shadow_count > 0) shadow_count--;
                hit = 1'b1;
            end
            if (hit) begin
                r.status = STATUS_OK;
                r.slot   = idx[SLOT_W-1:0];
            end
        end
        r.count = shadow_count[COUNT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    task automatic queue_req(input logic mode, input logic [KEY_W-1:0] key,
                             input logic [PAYLOAD_WIDTH-1:0] payload);
        t_req r;
        r.mode    = mode;
        r.key     = key;
        r.payload = payload;
        req_q.push_back(r);
    endtask

    // Mostly colliding pool keys, some extremes, the rest fully random
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 65) return key_pool[$urandom_range(POOL_N - 1)];
        if (roll < 70) return ($urandom_range(1) != 0) ? '1 : '0;
        return KEY_W'($urandom);
    endfunction

    // Bursts that lean towards filling or emptying the table
    task automatic load_random(input int n);
        int           left;
        int           burst;
        int unsigned  ins_pct;
        int unsigned  roll;
        logic [PAYLOAD_WIDTH-1:0] pay;
        left = n;
        while (left > 0) begin
            burst   = $urandom_range(60, 10);
            ins_pct = ($urandom_range(1) != 0) ? 85 : 30;
            if (burst > left) burst = left;
            repeat (burst) begin
                roll = $urandom_range(99);
                pay  = (roll < 3) ? '1 : (roll < 6) ? '0 : $urandom;
                queue_req(($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_REMOVE,
                          pick_key(), pay);
            end
            left -= burst;
        end
    endtask

    // Hold the sequence until the driver is empty and every result is in
    task automatic drain();
        while (req_q.size() != 0 || start || rsp_due_q.size() != 0)
            @(negedge i_clk);
    endtask

    // Driver: a new beat goes out once the previous one was taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_req <= req_q.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check result beats, then predict for a request beat
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (o_done) begin
                if (rsp_due_q.size() == 0) begin
                    flag_mismatch("result with none outstanding, slot", 0, o_rsp.slot);
                end else begin
                    want = rsp_due_q.pop_front();
                    if (o_rsp.status !== want.status)
                        flag_mismatch("status", want.status, o_rsp.status);
                    if (o_rsp.slot !== want.slot)
                        flag_mismatch("slot", want.slot, o_rsp.slot);
                    if (o_rsp.count !== want.count)
                        flag_mismatch("count", want.count, o_rsp.count);
                end
            end
            req_taken <= start && !busy;
            if (start && !busy) rsp_due_q.push_back(table_apply(i_req));
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sequence
    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
            shadow_pay[i]  = '0;
        end
        shadow_count = 0;

        // pool keys share a few home slots, two of them at the wrap point
        for (int i = 0; i < POOL_N; i++) begin
            key_pool[i] = KEY_W'((i % 4 == 0) ? 0 : (i % 4 == 1) ? 1 :
                                 (i % 4 == 2) ? 21 : 22);
            key_pool[i] = KEY_W'(key_pool[i] + TABLE_SIZE * $urandom_range(93000000));
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, collisions, wrap-round
        send_idle_pct = 0;
        queue_req(MODE_REMOVE, '0, '1);
        queue_req(MODE_INSERT, '0, '0);
        queue_req(MODE_INSERT, '1, '1);
        queue_req(MODE_INSERT, '0, 32'h5555_5555);
        queue_req(MODE_INSERT, 31'd23, 32'hAAAA_AAAA);
        queue_req(MODE_INSERT, 31'd22, 32'h0000_0001);
        queue_req(MODE_INSERT, 31'd45, 32'h8000_0000);
        queue_req(MODE_REMOVE, '0, '0);
        queue_req(MODE_REMOVE, 31'd45, '0);
        queue_req(MODE_REMOVE, 31'd99, '1);
        queue_req(MODE_INSERT, 31'd46, 32'hDEAD_BEEF);
        queue_req(MODE_REMOVE, '1, '0);
        queue_req(MODE_REMOVE, '1, '0);
        queue_req(MODE_REMOVE, 31'd22, '0);
        queue_req(MODE_REMOVE, '0, '0);
        queue_req(MODE_REMOVE, '0, '0);
        queue_req(MODE_REMOVE, 31'd23, '0);
        queue_req(MODE_REMOVE, 31'd46, '0);
        queue_req(MODE_INSERT, 31'h7FFF_FFFE, 32'hFFFF_FFFE);
        queue_req(MODE_REMOVE, 31'h7FFF_FFFE, '1);
        drain();

        // random sets with different sender gaps, draining in between
        send_idle_pct = 15;
        load_random(RANDOM_PER_SET);
        drain();
        send_idle_pct = 82;
        load_random(RANDOM_PER_SET);
        drain();
        send_idle_pct = 0;
        load_random(RANDOM_PER_SET);
        drain();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (rsp_due_q.size() != 0)
            flag_mismatch("results still outstanding", 0, rsp_due_q.size());
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/lpht_pkg.sv
hdl/lpht_datapath.sv
hdl/lpht_controller.sv
hdl/linear_probe_hash_table.sv
hdl/lpht_checker.sv
dv/tb_linear_probe_hash_table.sv
